[design/circular_deque_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the circular deque
// Wrappers for clocked concurrent assertions, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that must hold whenever an antecedent holds.
`define CDQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after an antecedent.
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CDQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define CDQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Field widths, opcodes, status codes and the result record of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int OPCODE_W = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 4;

  // Opcodes; the unused codes behave as a query.
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Result of one request, packed in the order of the output stream.
  typedef struct packed {
    logic                     is_full;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill_count;
    logic signed [WORD_W-1:0] rear_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
  } cdq_result_t;

endpackage

`default_nettype wire

[design/cdq_store.sv]
// ----------------------------------------------------------------------------
// cdq_store
// Slot memory with one write port and two registered look-ahead reads.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_store
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [AW-1:0]            wr_addr,
  input  wire signed [WORD_W-1:0] wr_data,
  input  wire [AW-1:0]            rd_front_addr,
  input  wire [AW-1:0]            rd_rear_addr,
  output logic signed [WORD_W-1:0] next_front,
  output logic signed [WORD_W-1:0] prev_rear
);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] next_front_r;
  logic signed [WORD_W-1:0] prev_rear_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports with forwarding of a write to the same slot.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_front_addr)) begin
      next_front_r <= wr_data;
    end else begin
      next_front_r <= mem[rd_front_addr];
    end
    if (wr_en && (wr_addr == rd_rear_addr)) begin
      prev_rear_r <= wr_data;
    end else begin
      prev_rear_r <= mem[rd_rear_addr];
    end
  end

  assign next_front = next_front_r;
  assign prev_rear  = prev_rear_r;

endmodule

`default_nettype wire

[design/cdq_core.sv]
// ----------------------------------------------------------------------------
// cdq_core
// Step logic: next indices, count, end words, slot write and result record.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire                      take,
  input  wire [OPCODE_W-1:0]       opcode,
  input  wire signed [WORD_W-1:0]  push_value,
  input  wire [AW-1:0]             head,
  input  wire [AW-1:0]             tail,
  input  wire [CW-1:0]             cnt,
  input  wire signed [WORD_W-1:0]  front,
  input  wire signed [WORD_W-1:0]  rear,
  input  wire signed [WORD_W-1:0]  next_front,
  input  wire signed [WORD_W-1:0]  prev_rear,
  output logic [AW-1:0]            head_nxt,
  output logic [AW-1:0]            tail_nxt,
  output logic [CW-1:0]            cnt_nxt,
  output logic signed [WORD_W-1:0] front_nxt,
  output logic signed [WORD_W-1:0] rear_nxt,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [WORD_W-1:0] wr_data,
  output logic [AW-1:0]            rd_front_addr,
  output logic [AW-1:0]            rd_rear_addr,
  output cdq_result_t              result
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic                     is_empty;
  logic                     is_full;
  logic [AW-1:0]            head_up;
  logic [AW-1:0]            head_dn;
  logic [AW-1:0]            tail_up;
  logic [AW-1:0]            tail_dn;
  logic [AW-1:0]            nh_up;
  logic [AW-1:0]            nt_dn;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] popped;
  logic [CW+FILL_W-1:0]     cnt_pad;

  assign is_empty = (cnt == '0);
  assign is_full  = (cnt == CW'(DEPTH));

  // Circular neighbors of the current indices.
  assign head_up = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign head_dn = (head == '0) ? LAST_IDX : head - AW'(1);
  assign tail_up = (tail == LAST_IDX) ? '0 : tail + AW'(1);
  assign tail_dn = (tail == '0) ? LAST_IDX : tail - AW'(1);

  // Apply the request to the state; idle cycles keep the state.
  always_comb begin
    head_nxt  = head;
    tail_nxt  = tail;
    cnt_nxt   = cnt;
    front_nxt = front;
    rear_nxt  = rear;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = push_value;
    status    = ST_DONE;
    popped    = '0;
    if (take) begin
      unique case (opcode)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (is_empty) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            cnt_nxt   = CW'(1);
            front_nxt = push_value;
            rear_nxt  = push_value;
            wr_en     = 1'b1;
          end else if (is_full) begin
            status = ST_FULL;
          end else if (opcode == OP_PUSH_FRONT) begin
            head_nxt  = head_dn;
            cnt_nxt   = cnt + CW'(1);
            front_nxt = push_value;
            wr_en     = 1'b1;
            wr_addr   = head_dn;
          end else begin
            tail_nxt = tail_up;
            cnt_nxt  = cnt + CW'(1);
            rear_nxt = push_value;
            wr_en    = 1'b1;
            wr_addr  = tail_up;
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (is_empty) begin
            status = ST_EMPTY;
          end else begin
            popped  = (opcode == OP_POP_FRONT) ? front : rear;
            cnt_nxt = cnt - CW'(1);
            if (cnt == CW'(1)) begin
              // Last word removed: back to the reset picture.
              head_nxt  = '0;
              tail_nxt  = '0;
              front_nxt = '0;
              rear_nxt  = '0;
            end else if (opcode == OP_POP_FRONT) begin
              head_nxt  = head_up;
              front_nxt = next_front;
            end else begin
              tail_nxt = tail_dn;
              rear_nxt = prev_rear;
            end
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  // Look-ahead reads follow the indices of the next state.
  assign nh_up = (head_nxt == LAST_IDX) ? '0 : head_nxt + AW'(1);
  assign nt_dn = (tail_nxt == '0) ? LAST_IDX : tail_nxt - AW'(1);
  assign rd_front_addr = nh_up;
  assign rd_rear_addr  = nt_dn;

  // Result record.
  assign cnt_pad = {{FILL_W{1'b0}}, cnt_nxt};
  always_comb begin
    result.status       = status;
    result.popped_value = popped;
    result.front_value  = front_nxt;
    result.rear_value   = rear_nxt;
    result.fill_count   = cnt_pad[FILL_W-1:0];
    result.is_empty     = (cnt_nxt == '0);
    result.is_full      = (cnt_nxt == CW'(DEPTH));
  end

endmodule

`default_nettype wire

[design/circular_deque.sv]
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a circular slot store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tdata carries the opcode and the
//   word to push. Every request gives exactly one result on the out_
//   stream: status, popped word, front and rear words, fill count and the
//   empty and full flags after the request.
//   The result is registered: a request taken at one edge shows its result
//   at out_tvalid after that edge. Throughput is one request per cycle
//   while out_tready is high; the front and rear words live in registers,
//   and two registered read ports of the slot memory deliver the neighbors
//   of both ends from next-state indices, so no step waits on a memory read.
//   Reset empties the deque at once and holds in_tready low; slot contents
//   are not cleared and never need to be. When the receiver holds
//   out_tready low, the result register keeps its request and in_tready
//   drops until it is taken; a request is accepted in the same cycle the
//   waiting result leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circular_deque_macros.svh"

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  // Request stream.
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [39:0]  in_tdata,   // [2:0] opcode, [34:3] push_value, [39:35] zero
  // Result stream.
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [103:0] out_tdata   // [1:0] status, [33:2] popped_value,
                                   // [65:34] front_value, [97:66] rear_value,
                                   // [101:98] fill_count, [102] is_empty,
                                   // [103] is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                     take;
  logic [OPCODE_W-1:0]      opcode;
  logic signed [WORD_W-1:0] push_value;

  logic [AW-1:0]            head_r, head_nxt;
  logic [AW-1:0]            tail_r, tail_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [WORD_W-1:0] front_r, front_nxt;
  logic signed [WORD_W-1:0] rear_r, rear_nxt;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic [AW-1:0]            rd_front_addr;
  logic [AW-1:0]            rd_rear_addr;
  logic signed [WORD_W-1:0] next_front;
  logic signed [WORD_W-1:0] prev_rear;

  cdq_result_t              result;
  logic                     out_tvalid_r;
  cdq_result_t              out_data_r;

  // Request unpacking and handshake; nothing is taken while in reset.
  assign opcode     = in_tdata[OPCODE_W-1:0];
  assign push_value = in_tdata[OPCODE_W+WORD_W-1:OPCODE_W];
  assign in_tready  = rst_n && (!out_tvalid_r || out_tready);
  assign take       = in_tvalid && in_tready;

  cdq_core #(.DEPTH(DEPTH)) u_core (
    .take          (take),
    .opcode        (opcode),
    .push_value    (push_value),
    .head          (head_r),
    .tail          (tail_r),
    .cnt           (cnt_r),
    .front         (front_r),
    .rear          (rear_r),
    .next_front    (next_front),
    .prev_rear     (prev_rear),
    .head_nxt      (head_nxt),
    .tail_nxt      (tail_nxt),
    .cnt_nxt       (cnt_nxt),
    .front_nxt     (front_nxt),
    .rear_nxt      (rear_nxt),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_front_addr (rd_front_addr),
    .rd_rear_addr  (rd_rear_addr),
    .result        (result)
  );

  cdq_store #(.DEPTH(DEPTH)) u_store (
    .clk           (clk),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_front_addr (rd_front_addr),
    .rd_rear_addr  (rd_rear_addr),
    .next_front    (next_front),
    .prev_rear     (prev_rear)
  );

  // Deque state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      front_r <= '0;
      rear_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Checks on the index bookkeeping and the reported flags.
  `CDQ_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= CW'(DEPTH), "fill count above depth")

  `CDQ_ASSERT_IMPLY(a_empty_idx, clk, rst_n,
    cnt_r == '0,
    (head_r == '0) && (tail_r == '0),
    "empty deque with indices away from slot zero")

  `CDQ_ASSERT_IMPLY(a_span, clk, rst_n,
    (cnt_r != '0) && (tail_r >= head_r),
    32'(tail_r) - 32'(head_r) + 32'd1 == 32'(cnt_r),
    "index span disagrees with fill count")

  `CDQ_ASSERT_IMPLY(a_full_flag, clk, rst_n,
    out_tvalid_r && (out_data_r.status == ST_FULL),
    out_data_r.is_full && !out_data_r.is_empty,
    "full refusal without full flag")

  `CDQ_ASSERT_NEXT(a_refuse_hold, clk, rst_n,
    take && (result.status != ST_DONE),
    (cnt_r == $past(cnt_r)) && (head_r == $past(head_r)) && (tail_r == $past(tail_r)),
    "refused request changed the deque")

endmodule

`default_nettype wire
